// ===== hw/rtl/racc_pkg.sv =====
package racc_pkg;

  localparam int COEF_FRAC_BITS = 12;
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int ROW_W   = 4 * COEF_W;
  localparam int NUM_CH  = 3;
  localparam int NUM_TERM = 4;
  // signed 16 x signed 9 (zero-extended pixel)
  localparam int PROD_W  = COEF_W + PIX_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int OFS_SHIFT = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [ROW_W-1:0] RED_ROW_RST   = ROW_W'(1) << COEF_FRAC_BITS;
  localparam logic [ROW_W-1:0] GREEN_ROW_RST = (ROW_W'(1) << COEF_FRAC_BITS) << COEF_W;
  localparam logic [ROW_W-1:0] BLUE_ROW_RST  = (ROW_W'(1) << COEF_FRAC_BITS) << (2 * COEF_W);

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    REG_RED_ROW   = 2'd0,
    REG_GREEN_ROW = 2'd1,
    REG_BLUE_ROW  = 2'd2
  } cfg_idx_t;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } in_pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
  } out_pix_t;

  // pipeline stage control shared by all stages
  typedef struct packed {
    logic adv;
    logic valid;
  } stg_ctl_t;

  function automatic coef_t coef_at(row_t row, logic [1:0] slot);
    coef_at = coef_t'(row[slot * COEF_W +: COEF_W]);
  endfunction

endpackage

// ===== hw/rtl/racc_mult.sv =====
module racc_mult
  import racc_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  stg_ctl_t                            ctl,
  input  in_pix_t                             in_data,
  input  row_t [NUM_CH-1:0]                   rows,
  output logic                                valid,
  output prod_t [NUM_CH-1:0][NUM_TERM-1:0]    prod
);

  logic [NUM_CH-1:0][PIX_W-1:0]            pix;
  prod_t [NUM_CH-1:0][NUM_TERM-1:0]        prod_next;

  assign pix[0] = in_data.in_red;
  assign pix[1] = in_data.in_green;
  assign pix[2] = in_data.in_blue;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        prod_next[ch][k] = prod_t'(coef_at(rows[ch], 2'(k))) *
                           prod_t'($signed({1'b0, pix[k]}));
      end
      // offset coefficient times 256
      prod_next[ch][NUM_TERM-1] = prod_t'($signed({coef_at(rows[ch], 2'(NUM_TERM - 1)),
                                                   {OFS_SHIFT{1'b0}}}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.adv) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== hw/rtl/racc_sum.sv =====
module racc_sum
  import racc_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  stg_ctl_t                            ctl,
  input  prod_t [NUM_CH-1:0][NUM_TERM-1:0]    prod,
  output logic                                valid,
  output sum_t [NUM_CH-1:0]                   sum
);

  sum_t [NUM_CH-1:0] sum_next;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_next[ch] = SUM_W'($signed(prod[ch][0])) + SUM_W'($signed(prod[ch][1]))
                   + SUM_W'($signed(prod[ch][2])) + SUM_W'($signed(prod[ch][3]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.adv) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sum <= sum_next;
    end
  end

endmodule

// ===== hw/rtl/racc_round.sv =====
module racc_round
  import racc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  stg_ctl_t           ctl,
  input  sum_t [NUM_CH-1:0]  sum,
  output logic               valid,
  output out_pix_t           out_data
);

  logic [NUM_CH-1:0][PIX_W-1:0] pix_next;
  logic [NUM_CH-1:0][SUM_W-1:0] quo;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      // only nonnegative sums use quo, so round half up is round half away
      quo[ch] = (sum[ch] + ROUND_HALF) >> COEF_FRAC_BITS;
      if (sum[ch][SUM_W-1]) begin
        pix_next[ch] = '0;
      end else if (quo[ch] > SUM_W'(PIX_MAX)) begin
        pix_next[ch] = PIX_MAX;
      end else begin
        pix_next[ch] = quo[ch][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.adv) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      out_data.out_red   <= pix_next[0];
      out_data.out_green <= pix_next[1];
      out_data.out_blue  <= pix_next[2];
    end
  end

endmodule

// ===== hw/rtl/rgb_affine_color_correction_unit.sv =====
// Pipeline: three registered stages from input transfer to output valid (multiply, sum, round/clamp).
// Throughput: one pixel per cycle; the three stages advance together whenever the
// output register is empty or being taken.
// Reset (rst, synchronous, active high): clears all stage valid bits and loads the
// identity matrix with zero offsets into the three coefficient rows.
module rgb_affine_color_correction_unit
  import racc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [ROW_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_pix_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_pix_t            out_data
);

  row_t [NUM_CH-1:0]                  rows;
  logic                               adv;
  logic                               s1_valid;
  logic                               s2_valid;
  prod_t [NUM_CH-1:0][NUM_TERM-1:0]   s1_prod;
  sum_t [NUM_CH-1:0]                  s2_sum;
  stg_ctl_t                           mult_ctl;
  stg_ctl_t                           sum_ctl;
  stg_ctl_t                           round_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= RED_ROW_RST;
      rows[1] <= GREEN_ROW_RST;
      rows[2] <= BLUE_ROW_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RED_ROW:   rows[0] <= cfg_data;
        REG_GREEN_ROW: rows[1] <= cfg_data;
        REG_BLUE_ROW:  rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the whole pipe only while a finished pixel waits on a stalled output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign mult_ctl  = {adv, in_valid};
  assign sum_ctl   = {adv, s1_valid};
  assign round_ctl = {adv, s2_valid};

  racc_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mult_ctl),
    .in_data (in_data),
    .rows    (rows),
    .valid   (s1_valid),
    .prod    (s1_prod)
  );

  racc_sum u_sum (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sum_ctl),
    .prod  (s1_prod),
    .valid (s2_valid),
    .sum   (s2_sum)
  );

  racc_round u_round (
    .clk      (clk),
    .rst      (rst),
    .ctl      (round_ctl),
    .sum      (s2_sum),
    .valid    (out_valid),
    .out_data (out_data)
  );

  a_three_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall ##1 !in_stall ##1 !in_stall) |=> out_valid)
    else $error("transferred pixel did not reach the output after three cycles");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && in_stall) |=> s2_valid)
    else $error("sum stage dropped an item during a stall");

  a_negative_clamps: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2_sum[0][SUM_W-1]) |=> (out_data.out_red == '0))
    else $error("negative red sum not clamped to zero");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import racc_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int MAX_GAP      = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 129;
  localparam int HOLD_AFTER   = 450;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;
  localparam int REPORT_LIMIT = 10;

  class color_checker;
    row_t rows[NUM_CH];
    out_pix_t expected_pixels[$];
    int failures;

    function new();
      rows[0] = RED_ROW_RST;
      rows[1] = GREEN_ROW_RST;
      rows[2] = BLUE_ROW_RST;
      failures = 0;
    endfunction

    function void set_row(logic [1:0] idx, row_t data);
      case (idx)
        REG_RED_ROW:   rows[0] = data;
        REG_GREEN_ROW: rows[1] = data;
        REG_BLUE_ROW:  rows[2] = data;
        default: ;
      endcase
    endfunction

    // exact dot product in 2^-COEF_FRAC_BITS units, round half up on magnitude, clamp
    function logic [PIX_W-1:0] apply_row(row_t row, in_pix_t p);
      coef_t c[NUM_TERM];
      longint acc;
      longint rounded;
      for (int k = 0; k < NUM_TERM; k++) c[k] = row[k*COEF_W +: COEF_W];
      acc = longint'(c[0]) * longint'(p.in_red) + longint'(c[1]) * longint'(p.in_green) +
            longint'(c[2]) * longint'(p.in_blue) + longint'(c[3]) * 256;
      if (acc < 0) return '0;
      rounded = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (rounded > 255) return PIX_MAX;
      return PIX_W'(rounded);
    endfunction

    function void note_pixel(in_pix_t p);
      out_pix_t w;
      w.out_red   = apply_row(rows[0], p);
      w.out_green = apply_row(rows[1], p);
      w.out_blue  = apply_row(rows[2], p);
      expected_pixels.push_back(w);
    endfunction

    function void check_pixel(out_pix_t got);
      out_pix_t want;
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected pixel: r=%0d g=%0d b=%0d",
                   got.out_red, got.out_green, got.out_blue);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.out_red, want.out_green, want.out_blue,
                   got.out_red, got.out_green, got.out_blue);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  row_t       cfg_data;
  logic       in_valid;
  logic       in_stall;
  in_pix_t    in_data;
  logic       out_valid;
  logic       out_stall;
  out_pix_t   out_data;

  color_checker sb;
  bit quiet;
  int results_seen;

  rgb_affine_color_correction_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_pixel(in_data);
      if (out_valid && !out_stall) begin
        sb.check_pixel(out_data);
        results_seen++;
      end
    end
  end

  // output side: random hold-off before each transfer, one long hold mid-run
  initial begin : result_sink
    int hold_cycles;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_cycles = HOLD_CYCLES;
      end else if (quiet) begin
        hold_cycles = 0;
      end else begin
        hold_cycles = $urandom_range(0, MAX_GAP);
      end
      repeat (hold_cycles) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic in_pix_t make_pixel(int r, int g, int b);
    in_pix_t p;
    p.in_red   = PIX_W'(r);
    p.in_green = PIX_W'(g);
    p.in_blue  = PIX_W'(b);
    return p;
  endfunction

  function automatic logic [PIX_W-1:0] random_channel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic row_t pack_row(coef_t gr, coef_t gg, coef_t gb, coef_t ofs);
    return {ofs, gb, gg, gr};
  endfunction

  function automatic coef_t random_coef();
    case ($urandom_range(0, 3))
      0:       return coef_t'($urandom);
      3:       return coef_t'(int'($urandom_range(0, 512)) - 256);
      default: return coef_t'(int'($urandom_range(0, 10240)) - 5120);
    endcase
  endfunction

  function automatic row_t random_row();
    case ($urandom_range(0, 7))
      0:       return {NUM_TERM{16'h7FFF}};
      1:       return {NUM_TERM{16'h8000}};
      default: return pack_row(random_coef(), random_coef(), random_coef(), random_coef());
    endcase
  endfunction

  task automatic send_pixel(input in_pix_t p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, wait for every expected pixel, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_row(input logic [1:0] idx, input row_t data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_row(idx, data);
  endtask

  task automatic load_matrix(input row_t red, input row_t green, input row_t blue);
    drain();
    write_row(REG_RED_ROW, red);
    write_row(REG_GREEN_ROW, green);
    write_row(REG_BLUE_ROW, blue);
  endtask

  initial begin : stimulus
    in_pix_t p;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    quiet     = 1'b0;
    results_seen = 0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity after reset
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(255, 255, 255));
    send_pixel(make_pixel(8'h80, 8'h40, 8'h01));
    send_pixel(make_pixel(8'hAA, 8'h55, 8'hFF));

    // halves: red 0.5*r, green 1 - 0.5*g, blue 1.5*b - 8; unknown index ignored
    load_matrix(pack_row(16'h0800, 16'h0000, 16'h0000, 16'h0000),
                pack_row(16'h0000, 16'hF800, 16'h0000, 16'h0010),
                pack_row(16'h0000, 16'h0000, 16'h1800, 16'hFF80));
    write_row(REG_NONE, {ROW_W{1'b1}});
    send_pixel(make_pixel(1, 1, 1));
    send_pixel(make_pixel(3, 3, 3));
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(255, 255, 255));
    send_pixel(make_pixel(1, 3, 9));
    send_pixel(make_pixel(5, 2, 11));
    send_pixel(make_pixel(255, 0, 255));
    send_pixel(make_pixel(0, 255, 0));

    // saturate high, then low
    load_matrix({NUM_TERM{16'h7FFF}}, {NUM_TERM{16'h7FFF}}, {NUM_TERM{16'h7FFF}});
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(255, 255, 255));
    send_pixel(make_pixel(0, 0, 1));
    load_matrix({NUM_TERM{16'h8000}}, {NUM_TERM{16'h8000}}, {NUM_TERM{16'h8000}});
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(255, 255, 255));
    send_pixel(make_pixel(1, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if ($urandom_range(0, 4) != 0) write_row(REG_RED_ROW, random_row());
      if ($urandom_range(0, 4) != 0) write_row(REG_GREEN_ROW, random_row());
      if ($urandom_range(0, 4) != 0) write_row(REG_BLUE_ROW, random_row());
      if ($urandom_range(0, 3) == 0) write_row(REG_NONE, {$urandom, $urandom});
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p.in_red   = random_channel();
        p.in_green = random_channel();
        p.in_blue  = random_channel();
        send_pixel(p);
      end
    end

    quiet = 1'b0;
    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
